### rtl/ips_pkg.sv
// Package for the irrigation pump scheduler: codes, word types and reset values.
package ips_pkg;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_CHANGING = 3'd1,
    ST_WAITING  = 3'd2,
    ST_PUMPING  = 3'd3,
    ST_ERROR    = 3'd4
  } state_e;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_BUTTON = 2'd1,
    MODE_WATER  = 2'd2,
    MODE_POT    = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam logic CFG_CHANGE_HOLD = 1'b0;
  localparam logic CFG_TICKS_PER_MIN = 1'b1;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] CHANGE_HOLD_RESET = 8'd30;
  localparam logic [5:0] TICKS_PER_MIN_RESET = 6'd60;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  pump_seconds;
    logic [13:0] interval_minutes;
    logic        water_present;
    logic        pot_channel;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        pump_on;
    logic [9:0]  seconds_left;
    logic [13:0] minutes_left;
    logic [7:0]  hold_left;
    logic        shown_channel;
    logic        no_water_seen;
    logic        error_lamp;
  } out_t;

  typedef struct packed {
    state_e      cur;
    state_e      saved;
    logic [9:0]  pump_cnt;
    logic [13:0] wait_cnt;
    logic [13:0] stored_int;
    logic [5:0]  tick;
    logic [7:0]  hold;
    logic        chan;
    logic        drive;
    logic        dry;
    logic        err;
    logic [9:0]  preset;
  } sched_t;

  localparam sched_t SCHED_RESET = '{
    cur:        ST_IDLE,
    saved:      ST_IDLE,
    pump_cnt:   10'd0,
    wait_cnt:   14'd0,
    stored_int: 14'd0,
    tick:       6'd0,
    hold:       8'd0,
    chan:       1'b0,
    drive:      1'b0,
    dry:        1'b0,
    err:        1'b0,
    preset:     10'd0
  };

endpackage

### rtl/ips_step.sv
// Next-state logic of the scheduler for one event word.
module ips_step (
  input  ips_pkg::sched_t state_i,
  input  ips_pkg::in_t    in_i,
  input  logic [7:0]      chs_i,
  input  logic [5:0]      tpm_i,
  output ips_pkg::sched_t state_o
);
  import ips_pkg::*;

  always_comb begin
    sched_t s;
    s = state_i;
    case (mode_e'(in_i.mode))
      MODE_TICK: begin
        // changing hold first, then pump on-time, then minute check
        if (s.cur == ST_CHANGING) begin
          if (s.hold <= 8'd1) begin
            s.hold = 8'd0;
            s.cur  = s.saved;
          end else begin
            s.hold = s.hold - 8'd1;
          end
        end
        if (s.cur == ST_PUMPING) begin
          if (s.pump_cnt <= 10'd1) begin
            s.pump_cnt = 10'd0;
            s.drive    = 1'b0;
            s.cur      = ST_WAITING;
            s.wait_cnt = s.stored_int;
          end else begin
            s.pump_cnt = s.pump_cnt - 10'd1;
          end
        end
        s.tick = s.tick + 6'd1;
        if (s.tick == tpm_i) begin
          s.tick = 6'd0;
          if (s.cur == ST_WAITING) begin
            if (s.wait_cnt <= 14'd1) begin
              s.wait_cnt = 14'd0;
              s.cur      = ST_PUMPING;
              s.drive    = 1'b1;
              s.pump_cnt = s.preset;
            end else begin
              s.wait_cnt = s.wait_cnt - 14'd1;
            end
          end
        end
      end
      MODE_BUTTON: begin
        s.err        = 1'b0;
        s.preset     = in_i.pump_seconds;
        s.stored_int = in_i.interval_minutes;
        s.cur        = ST_PUMPING;
        s.drive      = 1'b1;
        s.pump_cnt   = in_i.pump_seconds;
      end
      MODE_WATER: begin
        s.dry = ~in_i.water_present;
        if (!in_i.water_present) begin
          s.drive = 1'b0;
          if (s.cur == ST_PUMPING) begin
            s.wait_cnt = s.stored_int;
          end
          s.cur = ST_ERROR;
          s.err = 1'b1;
        end
      end
      MODE_POT: begin
        if (s.cur != ST_CHANGING) begin
          s.saved = s.cur;
        end
        s.cur  = ST_CHANGING;
        s.chan = in_i.pot_channel;
        s.hold = chs_i;
      end
      default: begin
        s = state_i;
      end
    endcase
    state_o = s;
  end

endmodule

### rtl/irrigation_pump_scheduler.sv
// Top level of the irrigation pump scheduler.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one event word:
//   tick, button press, water sample or pot change. Every accepted word gives
//   exactly one result word on the output channel (out_valid_o / out_stall_i /
//   out_data_o) with the scheduler state after that event.
//   Throughput: one word per cycle while the result register is not stalled. A
//   word lands in the input register, is stepped through the next-state logic
//   and shows on out_data_o from the result register.
//   The step logic between the input register and the result register is the
//   only work per word, so it sets that rate.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 change hold seconds, 1 ticks per minute); write only while idle.
//   Reset: rst_ni low clears all scheduler state to idle with the pump off,
//   loads the register defaults (30 s hold, 60 ticks per minute) and empties
//   both pipeline stages.
//   Stall: when out_stall_i holds a full result register, the input register
//   holds too and in_stall_o rises until the result is taken.
module irrigation_pump_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ips_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ips_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [ips_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ips_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import ips_pkg::*;

  logic [7:0] chs_val_q;
  logic [5:0] tpm_q;

  logic   in_valid_q;
  in_t    in_q;
  logic   out_valid_q;
  out_t   out_q;
  sched_t sched_q;
  sched_t sched_d;

  logic out_free;
  logic step_fire;
  logic in_take;

  // Result register can take a word when empty or being drained
  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_fire = in_valid_q && out_free;
  // Hold the input register while its word cannot move on
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chs_val_q <= CHANGE_HOLD_RESET;
      tpm_q     <= TICKS_PER_MIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANGE_HOLD:   chs_val_q <= cfg_wdata_i;
        CFG_TICKS_PER_MIN: tpm_q     <= cfg_wdata_i[5:0];
        default: begin
          chs_val_q <= chs_val_q;
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  ips_step u_step (
    .state_i (sched_q),
    .in_i    (in_q),
    .chs_i   (chs_val_q),
    .tpm_i   (tpm_q),
    .state_o (sched_d)
  );

  // Scheduler state advances only when the stepped word moves out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_q <= SCHED_RESET;
    end else if (step_fire) begin
      sched_q <= sched_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q.status        <= sched_d.cur;
      out_q.pump_on       <= sched_d.drive;
      out_q.seconds_left  <= sched_d.pump_cnt;
      out_q.minutes_left  <= sched_d.wait_cnt;
      out_q.hold_left     <= sched_d.hold;
      out_q.shown_channel <= sched_d.chan;
      out_q.no_water_seen <= sched_d.dry;
      out_q.error_lamp    <= sched_d.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/ips_checker.sv
// Port-level assertions for the irrigation pump scheduler, bound to the top level.
module ips_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  ips_pkg::in_t                     in_data_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  ips_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [ips_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ips_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import ips_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_ERROR)
    else $error("status code out of range");

  a_pumping_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_PUMPING |-> out_data_o.pump_on)
    else $error("pumping without pump drive");

  a_waiting_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_WAITING || out_data_o.status == ST_IDLE)
    |-> !out_data_o.pump_on)
    else $error("pump running while waiting or idle");

  a_error_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_ERROR |-> out_data_o.error_lamp)
    else $error("error state without error lamp");

endmodule

bind irrigation_pump_scheduler ips_checker u_ips_checker (.*);

### sim/tb_irrigation_pump_scheduler.sv
// Self-checking testbench for the irrigation pump scheduler: directed table, then random events.
module tb_irrigation_pump_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import ips_pkg::*;

  // Cycles without any handshake on either channel before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned WORDS_PER_PHASE = 130;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // One line of the directed script: either an event word or a register setting.
  typedef struct {
    row_kind_e  kind;
    logic [7:0] hold_val;
    logic [5:0] tpm_val;
    in_t        word;
    bit         typed;
    out_t       want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_word;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Status words still owed by the block, oldest first.
  out_t        status_due[$];
  out_t        due_word;
  int unsigned bad_words = 0;
  int unsigned hang_cycles = 0;
  // Set for one phase: neither side idles nor stalls.
  bit          steady = 1'b0;
  row_t        script[$];

  // Scheduler model state and its copy of the two registers.
  state_e      phase_now = ST_IDLE;
  state_e      phase_saved = ST_IDLE;
  logic [9:0]  run_secs = '0;
  logic [13:0] wait_mins = '0;
  logic [13:0] interval_keep = '0;
  logic [5:0]  minute_tick = '0;
  logic [7:0]  hold_secs = '0;
  logic        pot_shown = 1'b0;
  logic        pump_run = 1'b0;
  logic        dry_seen = 1'b0;
  logic        fault_lamp = 1'b0;
  logic [9:0]  run_preset = '0;
  logic [7:0]  hold_cfg = CHANGE_HOLD_RESET;
  logic [5:0]  tpm_cfg = TICKS_PER_MIN_RESET;

  irrigation_pump_scheduler i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler model
  // ---------------------------------------------------------------------------

  function automatic void pump_start();
    phase_now = ST_PUMPING;
    pump_run  = 1'b1;
    run_secs  = run_preset;
  endfunction

  // Drop the pump; a running irrigation falls back to waiting with a fresh interval.
  function automatic void pump_halt();
    pump_run = 1'b0;
    if (phase_now == ST_PUMPING) begin
      phase_now = ST_WAITING;
      wait_mins = interval_keep;
    end
  endfunction

  // Advance the model by one event word and return the status word it should give.
  function automatic out_t schedule_next(in_t w);
    out_t o;
    case (w.mode)
      MODE_TICK: begin
        // Changing hold first: on expiry restore the saved state, which may be pumping.
        if (phase_now == ST_CHANGING) begin
          if (hold_secs <= 8'd1) begin
            hold_secs = '0;
            phase_now = phase_saved;
          end else begin
            hold_secs = hold_secs - 8'd1;
          end
        end
        // Pump on-time next; counters loaded with zero expire here without wrapping.
        if (phase_now == ST_PUMPING) begin
          if (run_secs <= 10'd1) begin
            run_secs = '0;
            pump_halt();
          end else begin
            run_secs = run_secs - 10'd1;
          end
        end
        // Minute prescaler wraps modulo 64, so a setting below the count runs through 63.
        minute_tick = minute_tick + 6'd1;
        if (minute_tick == tpm_cfg) begin
          minute_tick = '0;
          if (phase_now == ST_WAITING) begin
            if (wait_mins <= 14'd1) begin
              wait_mins = '0;
              pump_start();
            end else begin
              wait_mins = wait_mins - 14'd1;
            end
          end
        end
      end
      MODE_BUTTON: begin
        fault_lamp    = 1'b0;
        run_preset    = w.pump_seconds;
        interval_keep = w.interval_minutes;
        pump_start();
      end
      MODE_WATER: begin
        // A wet sample only clears the dry lamp; a dry one forces error.
        dry_seen = ~w.water_present;
        if (!w.water_present) begin
          pump_halt();
          phase_now  = ST_ERROR;
          fault_lamp = 1'b1;
        end
      end
      MODE_POT: begin
        // A second pot change while changing keeps the saved state and restarts the hold.
        if (phase_now != ST_CHANGING) phase_saved = phase_now;
        phase_now = ST_CHANGING;
        pot_shown = w.pot_channel;
        hold_secs = hold_cfg;
      end
    endcase
    o.status        = phase_now;
    o.pump_on       = pump_run;
    o.seconds_left  = run_secs;
    o.minutes_left  = wait_mins;
    o.hold_left     = hold_secs;
    o.shown_channel = pot_shown;
    o.no_water_seen = dry_seen;
    o.error_lamp    = fault_lamp;
    return o;
  endfunction

  function automatic string show(out_t o);
    return $sformatf("st=%0d pump=%0b sec=%0d min=%0d hold=%0d ch=%0b dry=%0b err=%0b",
                     o.status, o.pump_on, o.seconds_left, o.minutes_left, o.hold_left,
                     o.shown_channel, o.no_water_seen, o.error_lamp);
  endfunction

  // ---------------------------------------------------------------------------
  // Script rows
  // ---------------------------------------------------------------------------

  function automatic row_t word_row(mode_e m, logic [9:0] ps, logic [13:0] im,
                                    logic wet, logic ch);
    row_t r;
    r.kind     = ROW_WORD;
    r.hold_val = '0;
    r.tpm_val  = '0;
    r.word     = '{m, ps, im, wet, ch};
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  // Attach a hand-written expectation to a word row.
  function automatic row_t checked_row(row_t r, out_t want);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [7:0] hold, logic [5:0] tpm);
    row_t r;
    r = word_row(MODE_TICK, '0, '0, 1'b0, 1'b0);
    r.kind     = ROW_CFG;
    r.hold_val = hold;
    r.tpm_val  = tpm;
    return r;
  endfunction

  // Random event: mostly ticks, small presets so the counters actually expire,
  // occasional full-range presets, and a fair share of dry samples and pot changes.
  function automatic in_t random_word();
    in_t         w;
    int unsigned pick;
    w    = in_t'(28'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      w.mode = MODE_TICK;
    end else if (pick < 72) begin
      w.mode = MODE_BUTTON;
      if ($urandom_range(0, 3) != 0) begin
        w.pump_seconds     = 10'($urandom_range(0, 6));
        w.interval_minutes = 14'($urandom_range(0, 3));
      end
    end else if (pick < 84) begin
      w.mode          = MODE_WATER;
      w.water_present = ($urandom_range(0, 3) != 0);
    end else begin
      w.mode = MODE_POT;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one event word, with random idle cycles in front; return at the edge that
  // takes it, leaving valid high so the next word can follow without a gap.
  task automatic push_word(in_t w, bit typed, out_t want);
    out_t guess;
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    guess = schedule_next(w);
    status_due.push_back(typed ? want : guess);
  endtask

  // Drop valid, wait for every owed word, then let the two-stage pipe empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; call only while the block is idle.
  task automatic write_regs(logic [7:0] hold, logic [5:0] tpm);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CHANGE_HOLD;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_idx   <= CFG_TICKS_PER_MIN;
    cfg_wdata <= {2'b00, tpm};
    @(posedge clk);
    cfg_we   <= 1'b0;
    hold_cfg = hold;
    tpm_cfg  = tpm;
  endtask

  // Receiver side: stall in about a fifth of the cycles except in the steady phase.
  always @(posedge clk) out_stall <= !steady && ($urandom_range(0, 99) < 20);

  // Check every taken result against the oldest owed word; watch for a hang.
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) hang_cycles <= 0;
      else hang_cycles <= hang_cycles + 1;
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) $display("unexpected result word: %s", show(out_word));
        end else begin
          due_word = status_due.pop_front();
          if (out_word.status !== due_word.status ||
              out_word.pump_on !== due_word.pump_on ||
              out_word.seconds_left !== due_word.seconds_left ||
              out_word.minutes_left !== due_word.minutes_left ||
              out_word.hold_left !== due_word.hold_left ||
              out_word.shown_channel !== due_word.shown_channel ||
              out_word.no_water_seen !== due_word.no_water_seen ||
              out_word.error_lamp !== due_word.error_lamp) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("mismatch expected: %s", show(due_word));
              $display("         actual:   %s", show(out_word));
            end
          end
        end
      end
      if (hang_cycles == HANG_LIMIT) begin
        $display("no handshake for %0d cycles", HANG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] hold_pick;
    logic [5:0] tpm_pick;

    // Directed part, starting from the reset values of both registers.
    script.push_back(checked_row(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0), '0));
    // Wet sample with every unused field at its maximum: nothing moves.
    script.push_back(checked_row(word_row(MODE_WATER, '1, '1, 1'b1, 1'b1), '0));
    // Dry sample from idle: straight to error with both lamps lit.
    script.push_back(checked_row(word_row(MODE_WATER, '0, '0, 1'b0, 1'b0),
                     '{ST_ERROR, 1'b0, 10'd0, 14'd0, 8'd0, 1'b0, 1'b1, 1'b1}));
    // Button with the largest presets clears the error lamp and starts pumping.
    script.push_back(checked_row(word_row(MODE_BUTTON, '1, '1, 1'b0, 1'b0),
                     '{ST_PUMPING, 1'b1, 10'd1023, 14'd0, 8'd0, 1'b0, 1'b1, 1'b0}));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_POT, '0, '0, 1'b0, 1'b1));
    // Pot change while already changing.
    script.push_back(word_row(MODE_POT, '1, '1, 1'b1, 1'b0));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    // Zero presets: the pump count expires on the very next tick.
    script.push_back(word_row(MODE_BUTTON, 10'd0, 14'd0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_WATER, '0, '0, 1'b0, 1'b0));
    // Dry while pumping: passes through waiting, which loads the interval.
    script.push_back(word_row(MODE_BUTTON, 10'd5, 14'd2, 1'b0, 1'b0));
    script.push_back(word_row(MODE_WATER, '1, '1, 1'b0, 1'b1));
    script.push_back(word_row(MODE_BUTTON, 10'h155, 14'h2AAA, 1'b1, 1'b1));
    script.push_back(word_row(MODE_BUTTON, 10'h2AA, 14'h1555, 1'b0, 1'b0));
    // Shortest hold and one tick per minute: hold expiry, pump expiry, wait expiry.
    script.push_back(cfg_row(8'd1, 6'd1));
    script.push_back(word_row(MODE_POT, '0, '0, 1'b0, 1'b1));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_BUTTON, 10'd1, 14'd2, 1'b0, 1'b0));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    // Zero hold and a zero minute setting (64 ticks per minute).
    script.push_back(cfg_row(8'd0, 6'd0));
    script.push_back(word_row(MODE_POT, '0, '0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_TICK, '0, '0, 1'b0, 1'b0));
    script.push_back(word_row(MODE_TICK, '1, '1, 1'b1, 1'b1));

    // Hold reset, then release it for good.
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain();
        write_regs(script[i].hold_val, script[i].tpm_val);
      end else begin
        push_word(script[i].word, script[i].typed, script[i].want);
      end
    end

    // Random phases: fixed settings first (largest, then one, then zero), then small random
    // settings (one of them with no idling at all), then a fully random setting.
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          hold_pick = 8'd255;
          tpm_pick  = 6'd63;
        end
        1: begin
          hold_pick = 8'd1;
          tpm_pick  = 6'd1;
        end
        2: begin
          hold_pick = 8'd0;
          tpm_pick  = 6'd0;
        end
        5: begin
          hold_pick = 8'($urandom_range(0, 255));
          tpm_pick  = 6'($urandom_range(0, 63));
        end
        default: begin
          hold_pick = 8'($urandom_range(0, 8));
          tpm_pick  = 6'($urandom_range(0, 6));
        end
      endcase
      steady = (p == 3);
      write_regs(hold_pick, tpm_pick);
      repeat (WORDS_PER_PHASE) push_word(random_word(), 1'b0, '0);
    end

    drain();
    if (bad_words == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
